>>> rtl/bwvwe_pkg.sv
// Shared constants and types for the binary-weighted value word encoder.
// No dependencies; imported by bwvwe_stage and the top level.
`default_nettype none

package bwvwe_pkg;

  localparam int unsigned VALUE_W = 16;   // measured value and full scale
  localparam int unsigned MAG_W   = 17;   // magnitude, holds 32768
  localparam int unsigned COUNT_W = 8;    // digit count field
  localparam int unsigned ADDR_W  = 13;   // address field
  localparam int unsigned WORD_W  = 32;   // response word

  localparam int unsigned VALID_BIT = 31;
  localparam int unsigned SIGN_BIT  = 28;
  localparam int unsigned TOP_BIT   = 27;

  typedef logic [MAG_W-1:0] mag_t;

endpackage : bwvwe_pkg

`default_nettype wire

>>> rtl/binary_weighted_value_word_encoder_top.sv
// Binary-weighted value word encoder: three register stages.
// Takes one item per cycle while the output is not held back by out_ready_i.
// Depth is set by the digit chain, split into two halves with a register between.
// Reset clears the stage valid flags only; payload registers are not reset.
// Depends on bwvwe_pkg and bwvwe_stage.
`default_nettype none

module binary_weighted_value_word_encoder_top #(
  parameter int unsigned MAX_DIGITS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [bwvwe_pkg::VALUE_W-1:0] measured_value_i,
  input  logic [bwvwe_pkg::VALUE_W-1:0]     full_scale_i,
  input  logic [bwvwe_pkg::COUNT_W-1:0]     digit_count_i,
  input  logic [bwvwe_pkg::ADDR_W-1:0]      target_address_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bwvwe_pkg::WORD_W-1:0]      response_word_o
);
  import bwvwe_pkg::*;

  localparam int unsigned HI_DIGITS = (MAX_DIGITS + 1) / 2;
  localparam int unsigned LO_DIGITS = MAX_DIGITS - HI_DIGITS;

  // Stage valid flags and load enables
  logic v1_q, v2_q, v3_q;
  logic ld1, ld2, ld3;

  assign ld3        = !v3_q || out_ready_i;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;

  // Stage 1: input register
  logic [VALUE_W-1:0] raw_q, full1_q;
  logic [COUNT_W-1:0] ndig1_q;
  logic [ADDR_W-1:0]  addr1_q;

  // Stage 2: magnitude after the upper digits
  mag_t                 mag2_q;
  logic [HI_DIGITS-1:0] hi2_q;
  logic [VALUE_W-1:0]   full2_q;
  logic [COUNT_W-1:0]   ndig2_q;
  logic [ADDR_W-1:0]    addr2_q;
  logic                 neg2_q;

  // Stage 3: result register
  logic [WORD_W-1:0] word_q, word_d;

  // Magnitude of the measurement and the upper digit steps
  logic                 neg1;
  mag_t                 mag1;
  mag_t                 mag2_d;
  logic [HI_DIGITS-1:0] hi2_d;

  assign neg1 = raw_q[VALUE_W-1];
  assign mag1 = neg1 ? (mag_t'(1) << VALUE_W) - MAG_W'(raw_q) : MAG_W'(raw_q);

  bwvwe_stage #(
    .FIRST (0),
    .COUNT (HI_DIGITS)
  ) u_stage_hi (
    .mag_i  (mag1),
    .full_i (full1_q),
    .mag_o  (mag2_d),
    .bits_o (hi2_d)
  );

  // Lower digit steps
  logic [MAX_DIGITS-1:0] pat_full;

  if (LO_DIGITS > 0) begin : g_lo
    logic [LO_DIGITS-1:0] lo_bits;

    bwvwe_stage #(
      .FIRST (HI_DIGITS),
      .COUNT (LO_DIGITS)
    ) u_stage_lo (
      .mag_i  (mag2_q),
      .full_i (full2_q),
      .mag_o  (),
      .bits_o (lo_bits)
    );

    assign pat_full = {hi2_q, lo_bits};
  end else begin : g_no_lo
    assign pat_full = hi2_q;
  end

  // Keep the first digit_count digits, complement for a negative value
  logic                  ndig_ok;
  logic [MAX_DIGITS-1:0] pat_mask;
  logic [MAX_DIGITS-1:0] pat_kept;
  logic [MAX_DIGITS-1:0] pat_out;

  assign ndig_ok  = (ndig2_q != '0) && (ndig2_q <= COUNT_W'(MAX_DIGITS));
  assign pat_mask = ~({MAX_DIGITS{1'b1}} >> ndig2_q);
  assign pat_kept = pat_full & pat_mask;
  assign pat_out  = neg2_q ? (~pat_kept + MAX_DIGITS'(1)) : pat_kept;

  always_comb begin
    word_d = '0;
    if (ndig_ok) begin
      word_d[VALID_BIT]                = 1'b1;
      word_d[SIGN_BIT]                 = neg2_q;
      word_d[TOP_BIT -: MAX_DIGITS]    = pat_out;
      word_d[ADDR_W-1:0]               = addr2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      raw_q   <= measured_value_i;
      full1_q <= full_scale_i;
      ndig1_q <= digit_count_i;
      addr1_q <= target_address_i;
    end
    if (ld2 && v1_q) begin
      mag2_q  <= mag2_d;
      hi2_q   <= hi2_d;
      full2_q <= full1_q;
      ndig2_q <= ndig1_q;
      addr2_q <= addr1_q;
      neg2_q  <= neg1;
    end
    if (ld3 && v2_q) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o     = v3_q;
  assign response_word_o = word_q;

`ifndef SYNTHESIS
  // Input stalls only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !out_ready_i))
    else $error("input stalled with a free stage");

  // An item in stage 1 moves on when stage 2 can load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && ld2) |=> v2_q)
    else $error("item dropped between stage 1 and stage 2");

  // A word without the valid flag is all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !response_word_o[VALID_BIT]) |-> (response_word_o == '0))
    else $error("invalid word carries stray bits");

  // Sign only on a valid word, and the unused bits stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((!response_word_o[SIGN_BIT] || response_word_o[VALID_BIT])
                     && (response_word_o[VALID_BIT-1:SIGN_BIT+1] == '0)))
    else $error("malformed response word");
`endif

endmodule : binary_weighted_value_word_encoder_top

`default_nettype wire

>>> rtl/bwvwe_stage.sv
// Group of greedy compare-subtract digit steps on the magnitude.
// Depends on bwvwe_pkg for widths.
`default_nettype none

module bwvwe_stage #(
  parameter int unsigned FIRST = 0,
  parameter int unsigned COUNT = 8
) (
  input  logic [bwvwe_pkg::MAG_W-1:0]   mag_i,
  input  logic [bwvwe_pkg::VALUE_W-1:0] full_i,
  output logic [bwvwe_pkg::MAG_W-1:0]   mag_o,
  output logic [COUNT-1:0]              bits_o
);
  import bwvwe_pkg::*;

  // Weight of step k is the full scale shifted right FIRST + k times; a zero
  // weight always matches.
  always_comb begin
    mag_t rem;
    mag_t wgt;
    rem    = mag_i;
    bits_o = '0;
    for (int k = 0; k < COUNT; k++) begin
      wgt = MAG_W'(full_i) >> (FIRST + k);
      if (rem >= wgt) begin
        bits_o[COUNT-1-k] = 1'b1;
        rem               = rem - wgt;
      end
    end
    mag_o = rem;
  end

endmodule : bwvwe_stage

`default_nettype wire
